FILE: hw/rtl/binary_heap_priority_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary heap priority queue checker.
// Each macro expands to one labelled concurrent assertion that reports by $error.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and codes for the binary heap priority queue controller,
// datapath and checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpq_pkg;

  localparam int KEY_PORT_W   = 32;
  localparam int STATUS_W     = 2;
  localparam int COUNT_PORT_W = 11;

  typedef logic [STATUS_W-1:0] hpq_status_t;

  localparam hpq_status_t STATUS_DONE  = 2'd0;
  localparam hpq_status_t STATUS_EMPTY = 2'd1;
  localparam hpq_status_t STATUS_FULL  = 2'd2;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic REG_POP_LARGEST_FIRST = 1'b0;
  localparam logic REG_KEYS_SIGNED       = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RM_LOAD,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } hpq_state_t;

  typedef enum logic [1:0] {
    RD_ROOT_LAST,
    RD_PARENT,
    RD_CHILDREN
  } hpq_rd_sel_t;

  typedef enum logic [1:0] {
    WR_MOVING,
    WR_PARENT,
    WR_CHILD
  } hpq_wr_src_t;

  typedef struct packed {
    logic        accept;
    logic        ins_start;
    logic        rm_start;
    logic        rm_load;
    hpq_rd_sel_t rd_sel;
    logic        wr_en;
    hpq_wr_src_t wr_src;
    logic        step_up;
    logic        step_down;
    logic        set_status;
    hpq_status_t status_code;
    logic        load_result;
  } hpq_cmd_t;

  typedef struct packed {
    logic kind;
    logic count_zero;
    logic count_full;
    logic index_zero;
    logic up_swap;
    logic down_swap;
    logic out_free;
  } hpq_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/hpq_ctrl.sv
// ----------------------------------------------------------------------------
// hpq_ctrl
// Controller state machine. Sequences one insert or removal transaction at a
// time through the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpq_ctrl
  import hpq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  hpq_flags_t flags,
  output hpq_cmd_t   cmd
);

  hpq_state_t state;
  hpq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.rd_sel      = RD_PARENT;
    cmd.wr_src      = WR_MOVING;
    cmd.status_code = STATUS_DONE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (flags.kind == KIND_INSERT) begin
          if (flags.count_full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STATUS_FULL;
            state_next      = ST_DONE;
          end else begin
            cmd.ins_start = 1'b1;
            state_next    = ST_UP_RD;
          end
        end else begin
          if (flags.count_zero) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STATUS_EMPTY;
            state_next      = ST_DONE;
          end else begin
            cmd.rm_start = 1'b1;
            cmd.rd_sel   = RD_ROOT_LAST;
            state_next   = ST_RM_LOAD;
          end
        end
      end
      ST_RM_LOAD: begin
        cmd.rm_load = 1'b1;
        state_next  = flags.count_zero ? ST_DONE : ST_DN_RD;
      end
      ST_UP_RD: begin
        if (flags.index_zero) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_src = WR_MOVING;
          state_next = ST_DONE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        cmd.wr_en = 1'b1;
        if (flags.up_swap) begin
          cmd.wr_src  = WR_PARENT;
          cmd.step_up = 1'b1;
          state_next  = ST_UP_RD;
        end else begin
          cmd.wr_src = WR_MOVING;
          state_next = ST_DONE;
        end
      end
      ST_DN_RD: begin
        cmd.rd_sel = RD_CHILDREN;
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (flags.down_swap) begin
          cmd.wr_src    = WR_CHILD;
          cmd.step_down = 1'b1;
          state_next    = ST_DN_RD;
        end else begin
          cmd.wr_src = WR_MOVING;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (flags.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/hpq_datapath.sv
// ----------------------------------------------------------------------------
// hpq_datapath
// Heap memory with one write and two registered read ports, entry count,
// sift index, moving key, key compare and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpq_datapath
  import hpq_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
)
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic                    cfg_data,
  input  logic                    kind,
  input  logic [KEY_PORT_W-1:0]   key,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [KEY_PORT_W-1:0]   out_key,
  output hpq_status_t             status,
  output logic [COUNT_PORT_W-1:0] count,
  input  hpq_cmd_t                cmd,
  output hpq_flags_t              flags
);

  localparam int KW = KEY_WIDTH;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;
  localparam logic [KW-1:0] SIGN_MASK = KW'(1) << (KW - 1);

  logic [KW-1:0] heap_mem [CAPACITY];

  logic          pop_largest_first;
  logic          keys_signed;
  logic          kind_reg;
  logic [CW-1:0] entry_count;
  logic [AW-1:0] idx;
  logic [KW-1:0] moving;
  logic [KW-1:0] removed;
  hpq_status_t   res_status;
  logic [KW-1:0] rdata_a;
  logic [KW-1:0] rdata_b;

  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] parent_idx;
  logic [XW-1:0] left_idx;
  logic [XW-1:0] right_idx;
  logic [XW-1:0] count_x;
  logic          left_ok;
  logic          right_ok;
  logic          left_wins;
  logic          right_wins;
  logic [KW-1:0] best_val;
  logic [KW-1:0] wdata;
  logic [63:0]   key_ext;
  logic [63:0]   removed_ext;
  logic [31:0]   count_ext;

  function automatic logic outranks(input logic [KW-1:0] a, input logic [KW-1:0] b,
                                    input logic largest, input logic signd);
    logic [KW-1:0] sa;
    logic [KW-1:0] sb;
    sa = signd ? (a ^ SIGN_MASK) : a;
    sb = signd ? (b ^ SIGN_MASK) : b;
    return largest ? (sa > sb) : (sa < sb);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_largest_first <= 1'b1;
      keys_signed       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POP_LARGEST_FIRST: pop_largest_first <= cfg_data;
        REG_KEYS_SIGNED:       keys_signed       <= cfg_data;
        default:               pop_largest_first <= pop_largest_first;
      endcase
    end
  end

  assign parent_idx = (idx - 1'b1) >> 1;
  assign left_idx   = {1'b0, idx, 1'b1};
  assign right_idx  = {1'b0, idx, 1'b0} + XW'(2);
  assign count_x    = XW'(entry_count);
  assign left_ok    = left_idx < count_x;
  assign right_ok   = right_idx < count_x;

  always_comb begin
    addr_a = '0;
    addr_b = '0;
    unique case (cmd.rd_sel)
      RD_ROOT_LAST: begin
        addr_a = '0;
        addr_b = AW'(entry_count - 1'b1);
      end
      RD_PARENT: begin
        addr_a = parent_idx;
      end
      RD_CHILDREN: begin
        addr_a = left_idx[AW-1:0];
        addr_b = right_idx[AW-1:0];
      end
      default: begin
        addr_a = '0;
      end
    endcase
  end

  assign left_wins  = left_ok && outranks(rdata_a, moving, pop_largest_first, keys_signed);
  assign best_val   = left_wins ? rdata_a : moving;
  assign right_wins = right_ok && outranks(rdata_b, best_val, pop_largest_first, keys_signed);

  always_comb begin
    unique case (cmd.wr_src)
      WR_MOVING: wdata = moving;
      WR_PARENT: wdata = rdata_a;
      WR_CHILD:  wdata = right_wins ? rdata_b : rdata_a;
      default:   wdata = moving;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      heap_mem[idx] <= wdata;
    end
    rdata_a <= heap_mem[addr_a];
    rdata_b <= heap_mem[addr_b];
  end

  assign key_ext = 64'(key);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.ins_start) begin
      entry_count <= entry_count + 1'b1;
    end else if (cmd.rm_start) begin
      entry_count <= entry_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_reg   <= kind;
      moving     <= key_ext[KW-1:0];
      removed    <= '0;
      res_status <= STATUS_DONE;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
    if (cmd.ins_start) begin
      idx <= AW'(entry_count);
    end else if (cmd.rm_start) begin
      idx <= '0;
    end else if (cmd.step_up) begin
      idx <= parent_idx;
    end else if (cmd.step_down) begin
      idx <= right_wins ? right_idx[AW-1:0] : left_idx[AW-1:0];
    end
    if (cmd.rm_load) begin
      removed <= rdata_a;
      moving  <= rdata_b;
    end
  end

  assign removed_ext = 64'(removed);
  assign count_ext   = 32'(entry_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_key <= removed_ext[KEY_PORT_W-1:0];
      status  <= res_status;
      count   <= count_ext[COUNT_PORT_W-1:0];
    end
  end

  assign flags.kind       = kind_reg;
  assign flags.count_zero = (entry_count == '0);
  assign flags.count_full = (entry_count == CW'(CAPACITY));
  assign flags.index_zero = (idx == '0);
  assign flags.up_swap    = outranks(moving, rdata_a, pop_largest_first, keys_signed);
  assign flags.down_swap  = left_wins || right_wins;
  assign flags.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/binary_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// Array-backed binary heap priority queue: insert a key or remove the top key.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// cfg       cfg_write              cfg_index, cfg_data
// in        in_valid / in_ready    kind, key
// out       out_valid / out_ready  out_key, status, count
//
// One transaction is worked on at a time. An insert sifts its key up from the
// end of the heap to the root or a lower stop; a removal sifts the last entry
// down from the root. Either makes at most 10 swaps at a capacity of 1024; a
// removal that empties the heap makes none, and a dropped insert or a removal
// on an empty heap only sets its status. Reset is synchronous and empties the
// heap; memory contents are not cleared. A result waiting in the output
// register holds the machine in its last state until the register is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue_unit
  import hpq_pkg::*;
#(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 32
)
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic                    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic [KEY_PORT_W-1:0]   key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KEY_PORT_W-1:0]   out_key,
  output hpq_status_t             status,
  output logic [COUNT_PORT_W-1:0] count
);

  hpq_cmd_t   cmd;
  hpq_flags_t flags;

  hpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  hpq_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .kind      (kind),
    .key       (key),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_key   (out_key),
    .status    (status),
    .count     (count),
    .cmd       (cmd),
    .flags     (flags)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/hpq_checker.sv
// ----------------------------------------------------------------------------
// hpq_checker
// Port-level checks on the binary heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "binary_heap_priority_queue_unit_defines.svh"

module hpq_checker
  import hpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [KEY_PORT_W-1:0]   out_key,
  input  hpq_status_t             status,
  input  logic [COUNT_PORT_W-1:0] count
);

  localparam int OW = KEY_PORT_W + STATUS_W + COUNT_PORT_W;

  logic          in_fire;
  logic          out_stall;
  logic [OW-1:0] out_word;
  logic          empty_res;
  logic          empty_ok;
  logic          full_res;
  logic          full_ok;

  assign in_fire   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;
  assign out_word  = {out_key, status, count};
  assign empty_res = out_valid && status == STATUS_EMPTY;
  assign empty_ok  = count == '0 && out_key == '0;
  assign full_res  = out_valid && status == STATUS_FULL;
  assign full_ok   = out_key == '0 && count != '0;

  `HPQ_ASSERT_NEXT(a_hold, clk, rst, out_stall, out_valid && $stable(out_word), "Result changed.")
  `HPQ_ASSERT_NEXT(a_busy, clk, rst, in_fire, !in_ready, "Input accepted twice in a row.")
  `HPQ_ASSERT_SAME(a_empty, clk, rst, empty_res, empty_ok, "Empty remove gave a key or count.")
  `HPQ_ASSERT_SAME(a_full, clk, rst, full_res, full_ok, "Dropped insert gave a key or no count.")

endmodule

bind binary_heap_priority_queue_unit hpq_checker u_hpq_checker (.*);

`default_nettype wire
